// ----- rtl/core/nmsc_pkg.sv -----
package nmsc_pkg;

  localparam int DEF_LINE_LIMIT = 127;
  localparam int DEF_MAX_FIELDS = 20;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  localparam logic [3:0] KIND_OTHER = 4'd0;
  localparam logic [3:0] KIND_MWV   = 4'd1;
  localparam logic [3:0] KIND_RMC   = 4'd2;
  localparam logic [3:0] KIND_GGA   = 4'd3;
  localparam logic [3:0] KIND_VTG   = 4'd4;
  localparam logic [3:0] KIND_HDG   = 4'd5;
  localparam logic [3:0] KIND_HDT   = 4'd6;
  localparam logic [3:0] KIND_XDR   = 4'd7;
  localparam logic [3:0] KIND_VDM   = 4'd8;

  typedef struct packed {
    logic       checksum_ok;
    logic [3:0] sentence_kind;
    logic [4:0] field_count;
    logic [6:0] line_length;
  } nmsc_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r = '{is_hex: 1'b0, nibble: 4'd0};
    if (c inside {[8'h30:8'h39]}) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - 8'h61 + 8'd10);
    end
    return r;
  endfunction

  function automatic logic [3:0] kind_of_tag(input logic [23:0] tag);
    logic [3:0] k;
    case (tag)
      "MWV":   k = KIND_MWV;
      "RMC":   k = KIND_RMC;
      "GGA":   k = KIND_GGA;
      "VTG":   k = KIND_VTG;
      "HDG":   k = KIND_HDG;
      "HDT":   k = KIND_HDT;
      "XDR":   k = KIND_XDR;
      "VDM":   k = KIND_VDM;
      "VDO":   k = KIND_VDM;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/nmsc_line_tracker.sv -----
module nmsc_line_tracker #(
  parameter int LINE_LIMIT = nmsc_pkg::DEF_LINE_LIMIT,
  parameter int MAX_FIELDS = nmsc_pkg::DEF_MAX_FIELDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  output logic                  done_o,
  output nmsc_pkg::nmsc_result_t result_o
);

  localparam int CntW = $clog2(LINE_LIMIT + 1);

  logic [CntW-1:0] char_count_q, char_count_d;
  logic [7:0]      xor_sum_q, xor_sum_d;
  logic            star_seen_q, star_seen_d;
  logic [1:0]      after_star_count_q, after_star_count_d;
  logic [7:0]      hex_value_q, hex_value_d;
  logic            hex_open_q, hex_open_d;
  logic            lead_ok_q, lead_ok_d;
  logic            tag_open_q, tag_open_d;
  logic [2:0]      tag_length_q, tag_length_d;
  logic [2:0]      star_tag_len_q, star_tag_len_d;
  logic [23:0]     type_chars_q, type_chars_d;
  logic [4:0]      comma_count_q, comma_count_d;

  logic                 is_eol;
  logic                 is_star;
  logic                 is_comma;
  nmsc_pkg::hex_digit_t digit;
  logic [2:0]           kind_len;

  assign is_eol   = (byte_i == nmsc_pkg::CHAR_LF) || (byte_i == nmsc_pkg::CHAR_CR);
  assign is_star  = (byte_i == nmsc_pkg::CHAR_STAR);
  assign is_comma = (byte_i == nmsc_pkg::CHAR_COMMA);
  assign digit    = nmsc_pkg::hex_digit(byte_i);
  assign done_o   = is_eol && (char_count_q != '0);

  always_comb begin
    char_count_d       = char_count_q;
    xor_sum_d          = xor_sum_q;
    star_seen_d        = star_seen_q;
    after_star_count_d = after_star_count_q;
    hex_value_d        = hex_value_q;
    hex_open_d         = hex_open_q;
    lead_ok_d          = lead_ok_q;
    tag_open_d         = tag_open_q;
    tag_length_d       = tag_length_q;
    star_tag_len_d     = star_tag_len_q;
    type_chars_d       = type_chars_q;
    comma_count_d      = comma_count_q;
    if (fire_i) begin
      if (is_eol) begin
        char_count_d       = '0;
        xor_sum_d          = '0;
        star_seen_d        = 1'b0;
        after_star_count_d = '0;
        hex_value_d        = '0;
        hex_open_d         = 1'b1;
        lead_ok_d          = 1'b0;
        tag_open_d         = 1'b1;
        tag_length_d       = '0;
        star_tag_len_d     = '0;
        type_chars_d       = '0;
        comma_count_d      = '0;
      end else if (char_count_q < CntW'(LINE_LIMIT)) begin
        if (char_count_q == '0) begin
          lead_ok_d = (byte_i == nmsc_pkg::CHAR_DOLLAR) || (byte_i == nmsc_pkg::CHAR_BANG);
        end
        if (!star_seen_q) begin
          if (is_star) begin
            star_seen_d = 1'b1;
            if (tag_open_q) begin
              star_tag_len_d = tag_length_q;
            end
          end else if (char_count_q != '0) begin
            xor_sum_d = xor_sum_q ^ byte_i;
          end
        end else begin
          if (after_star_count_q != 2'd3) begin
            after_star_count_d = after_star_count_q + 2'd1;
          end
          if (hex_open_q) begin
            if (digit.is_hex) begin
              hex_value_d = {hex_value_q[3:0], digit.nibble};
            end else begin
              hex_open_d = 1'b0;
            end
          end
        end
        if (tag_open_q) begin
          if (is_comma) begin
            tag_open_d = 1'b0;
          end else begin
            if (char_count_q == CntW'(3)) type_chars_d[23:16] = byte_i;
            if (char_count_q == CntW'(4)) type_chars_d[15:8]  = byte_i;
            if (char_count_q == CntW'(5)) type_chars_d[7:0]   = byte_i;
            if (tag_length_q != 3'd7) begin
              tag_length_d = tag_length_q + 3'd1;
            end
          end
        end
        if (is_comma && (comma_count_q < 5'(MAX_FIELDS - 1))) begin
          comma_count_d = comma_count_q + 5'd1;
        end
        char_count_d = char_count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q       <= '0;
      xor_sum_q          <= '0;
      star_seen_q        <= 1'b0;
      after_star_count_q <= '0;
      hex_value_q        <= '0;
      hex_open_q         <= 1'b1;
      lead_ok_q          <= 1'b0;
      tag_open_q         <= 1'b1;
      tag_length_q       <= '0;
      star_tag_len_q     <= '0;
      type_chars_q       <= '0;
      comma_count_q      <= '0;
    end else begin
      char_count_q       <= char_count_d;
      xor_sum_q          <= xor_sum_d;
      star_seen_q        <= star_seen_d;
      after_star_count_q <= after_star_count_d;
      hex_value_q        <= hex_value_d;
      hex_open_q         <= hex_open_d;
      lead_ok_q          <= lead_ok_d;
      tag_open_q         <= tag_open_d;
      tag_length_q       <= tag_length_d;
      star_tag_len_q     <= star_tag_len_d;
      type_chars_q       <= type_chars_d;
      comma_count_q      <= comma_count_d;
    end
  end

  assign kind_len = (tag_open_q && star_seen_q) ? star_tag_len_q : tag_length_q;

  always_comb begin
    result_o.checksum_ok   = lead_ok_q && star_seen_q && (after_star_count_q >= 2'd2) &&
                             (xor_sum_q == hex_value_q);
    result_o.sentence_kind = (lead_ok_q && (kind_len == 3'd6)) ?
                             nmsc_pkg::kind_of_tag(type_chars_q) : nmsc_pkg::KIND_OTHER;
    result_o.field_count   = comma_count_q + 5'd1;
    result_o.line_length   = 7'(char_count_q);
  end

endmodule

// ----- rtl/core/nmsc_result_reg.sv -----
module nmsc_result_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  nmsc_pkg::nmsc_result_t result_i,
  input  logic                   stall_i,
  output logic                   valid_o,
  output nmsc_pkg::nmsc_result_t result_o
);

  logic                   valid_q, valid_d;
  nmsc_pkg::nmsc_result_t result_q;

  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- rtl/core/nmea_sentence_checksum_framer.sv -----
// NMEA 0183 line framer: takes one received byte per cycle while the input is not stalled,
// frames lines on CR or LF and, for each non-empty line, returns the checksum verdict,
// sentence kind, capped field count and kept length. The path is an input register, a
// single update of the running line state (XOR, small counters, tag capture) and a result
// register, so a line's result reaches the output through the input register and then the
// result register. Input stall rises only when the end of a non-empty line reaches the input
// register while the previous result is still stalled at the output.
module nmea_sentence_checksum_framer #(
  parameter int LINE_LIMIT = nmsc_pkg::DEF_LINE_LIMIT,
  parameter int MAX_FIELDS = nmsc_pkg::DEF_MAX_FIELDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       checksum_ok_o,
  output logic [3:0] sentence_kind_o,
  output logic [4:0] field_count_o,
  output logic [6:0] line_length_o
);

  logic                   in_valid_q, in_valid_d;
  logic [7:0]             in_byte_q;
  logic                   in_accept;
  logic                   advance;
  logic                   fire;
  logic                   done;
  nmsc_pkg::nmsc_result_t line_result;
  nmsc_pkg::nmsc_result_t out_result;

  assign advance    = !(in_valid_q && done && out_valid_o && out_stall_i);
  assign fire       = in_valid_q && advance;
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;
  assign in_valid_d = advance ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  nmsc_line_tracker #(
    .LINE_LIMIT(LINE_LIMIT),
    .MAX_FIELDS(MAX_FIELDS)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte_q),
    .done_o  (done),
    .result_o(line_result)
  );

  nmsc_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && done),
    .result_i(line_result),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .result_o(out_result)
  );

  assign checksum_ok_o   = out_result.checksum_ok;
  assign sentence_kind_o = out_result.sentence_kind;
  assign field_count_o   = out_result.field_count;
  assign line_length_o   = out_result.line_length;

endmodule

// ----- rtl/core/nmsc_checker.sv -----
module nmsc_checker #(
  parameter int LINE_LIMIT = nmsc_pkg::DEF_LINE_LIMIT,
  parameter int MAX_FIELDS = nmsc_pkg::DEF_MAX_FIELDS
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       checksum_ok_o,
  input logic [3:0] sentence_kind_o,
  input logic [4:0] field_count_o,
  input logic [6:0] line_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (field_count_o != 5'd0) && (field_count_o <= 5'(MAX_FIELDS)))
    else $error("field count out of range");

  a_kind_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sentence_kind_o != nmsc_pkg::KIND_OTHER) |->
      (sentence_kind_o <= nmsc_pkg::KIND_VDM) &&
      ((LINE_LIMIT > 127) || (line_length_o >= 7'd6)))
    else $error("sentence kind inconsistent with line length");

  a_no_empty_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (LINE_LIMIT > 127) || (line_length_o != 7'd0))
    else $error("result for an empty line");

  a_rose_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a request two cycles earlier");

  logic unused_in_byte;
  logic unused_ok;
  assign unused_in_byte = ^in_byte_i;
  assign unused_ok      = checksum_ok_o;

endmodule

bind nmea_sentence_checksum_framer nmsc_checker #(
  .LINE_LIMIT(LINE_LIMIT),
  .MAX_FIELDS(MAX_FIELDS)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_byte_i      (in_byte_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .checksum_ok_o  (checksum_ok_o),
  .sentence_kind_o(sentence_kind_o),
  .field_count_o  (field_count_o),
  .line_length_o  (line_length_o)
);

// ----- tb/nmea_line_checker.sv -----
module nmea_line_checker
  import nmsc_pkg::*;
#(
  parameter int LINE_LIMIT = DEF_LINE_LIMIT,
  parameter int MAX_FIELDS = DEF_MAX_FIELDS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       checksum_ok_i,
  input  logic [3:0] sentence_kind_i,
  input  logic [4:0] field_count_i,
  input  logic [6:0] line_length_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         results_checked_o
);

  nmsc_result_t line_results_q[$];

  int         kept;
  logic [7:0] xor_acc;
  logic [7:0] star_hex;
  logic       star_found;
  logic       hex_live;
  logic       lead_good;
  logic       tag_live;
  logic [1:0] post_star;
  logic [2:0] tag_len;
  logic [2:0] tag_len_at_star;
  logic [7:0] tag_chr[3];
  logic [4:0] commas;

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic [3:0] line_kind();
    logic [2:0]  len;
    logic [23:0] t;
    len = (tag_live && star_found) ? tag_len_at_star : tag_len;
    t = {tag_chr[0], tag_chr[1], tag_chr[2]};
    if (!lead_good || len != 3'd6) return KIND_OTHER;
    if (t == "MWV") return KIND_MWV;
    if (t == "RMC") return KIND_RMC;
    if (t == "GGA") return KIND_GGA;
    if (t == "VTG") return KIND_VTG;
    if (t == "HDG") return KIND_HDG;
    if (t == "HDT") return KIND_HDT;
    if (t == "XDR") return KIND_XDR;
    if (t == "VDM" || t == "VDO") return KIND_VDM;
    return KIND_OTHER;
  endfunction

  task automatic clear_line();
    kept = 0;
    xor_acc = '0;
    star_hex = '0;
    star_found = 1'b0;
    hex_live = 1'b1;
    lead_good = 1'b0;
    tag_live = 1'b1;
    post_star = '0;
    tag_len = '0;
    tag_len_at_star = '0;
    tag_chr = '{default: '0};
    commas = '0;
  endtask

  task automatic absorb(logic [7:0] c);
    int d;
    if (kept == 0) lead_good = (c == CHAR_DOLLAR || c == CHAR_BANG);
    if (!star_found) begin
      if (c == CHAR_STAR) begin
        star_found = 1'b1;
        if (tag_live) tag_len_at_star = tag_len;
      end else if (kept >= 1) begin
        xor_acc ^= c;
      end
    end else begin
      if (post_star != 2'd3) post_star++;
      if (hex_live) begin
        d = nibble_of(c);
        if (d >= 0) star_hex = {star_hex[3:0], 4'(d)};
        else hex_live = 1'b0;
      end
    end
    if (tag_live) begin
      if (c == CHAR_COMMA) begin
        tag_live = 1'b0;
      end else begin
        if (kept >= 3 && kept <= 5) tag_chr[kept-3] = c;
        if (tag_len != 3'd7) tag_len++;
      end
    end
    if (c == CHAR_COMMA && commas < 5'(MAX_FIELDS - 1)) commas++;
    kept++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nmsc_result_t want;
    if (!rst_ni) begin
      clear_line();
      line_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      results_checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (in_byte_i == CHAR_LF || in_byte_i == CHAR_CR) begin
          if (kept != 0) begin
            want.checksum_ok = lead_good && star_found && post_star >= 2'd2 &&
                               xor_acc == star_hex;
            want.sentence_kind = line_kind();
            want.field_count = commas + 5'd1;
            want.line_length = kept[6:0];
            line_results_q.push_back(want);
            clear_line();
          end
        end else if (kept < LINE_LIMIT) begin
          absorb(in_byte_i);
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (line_results_q.size() == 0) begin
          $error("line result with no line end pending");
          fail_count_o++;
        end else begin
          want = line_results_q.pop_front();
          results_checked_o++;
          if (checksum_ok_i !== want.checksum_ok) begin
            $error("checksum_ok expected %0d got %0d", want.checksum_ok, checksum_ok_i);
            fail_count_o++;
          end
          if (sentence_kind_i !== want.sentence_kind) begin
            $error("sentence_kind expected %0d got %0d", want.sentence_kind,
                   sentence_kind_i);
            fail_count_o++;
          end
          if (field_count_i !== want.field_count) begin
            $error("field_count expected %0d got %0d", want.field_count, field_count_i);
            fail_count_o++;
          end
          if (line_length_i !== want.line_length) begin
            $error("line_length expected %0d got %0d", want.line_length, line_length_i);
            fail_count_o++;
          end
        end
      end
      pending_o = line_results_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import nmsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    SUM_UPPER,
    SUM_LOWER,
    SUM_ONE,
    SUM_NONE,
    SUM_THREE,
    SUM_WRONG,
    SUM_NONHEX,
    SUM_TRAIL,
    NO_STAR
  } sum_style_e;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       checksum_ok_o;
  logic [3:0] sentence_kind_o;
  logic [4:0] field_count_o;
  logic [6:0] line_length_o;

  int         fail_count;
  int         pending;
  int         results_checked;
  int         idle_cycles = 0;
  int         sent_bytes = 0;
  int         sent_lines = 0;
  bit         quiet = 1'b0;
  logic [7:0] line_buf[$];
  string      type_names[9] = '{"MWV", "RMC", "GGA", "VTG", "HDG", "HDT", "XDR", "VDM",
                                "VDO"};

  nmea_sentence_checksum_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .checksum_ok_o  (checksum_ok_o),
    .sentence_kind_o(sentence_kind_o),
    .field_count_o  (field_count_o),
    .line_length_o  (line_length_o)
  );

  nmea_line_checker u_line_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .checksum_ok_i    (checksum_ok_o),
    .sentence_kind_i  (sentence_kind_o),
    .field_count_i    (field_count_o),
    .line_length_i    (line_length_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_checked_o(results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] line_sum();
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < line_buf.size(); i++) s ^= line_buf[i];
    return s;
  endfunction

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == CHAR_STAR || c == CHAR_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_sum(logic [7:0] s, sum_style_e st);
    bit lower;
    lower = (st == SUM_LOWER);
    if (st == NO_STAR) return;
    line_buf.push_back(CHAR_STAR);
    case (st)
      SUM_NONE: ;
      SUM_ONE: line_buf.push_back(hex_char(s[3:0], 1'b0));
      default: begin
        if (st == SUM_NONHEX) line_buf.push_back("G");
        if (st == SUM_THREE) line_buf.push_back("0");
        if (st == SUM_WRONG) s ^= 8'($urandom_range(1, 255));
        line_buf.push_back(hex_char(s[7:4], lower));
        line_buf.push_back(hex_char(s[3:0], lower));
        if (st == SUM_TRAIL) put_text(",1.0,T");
      end
    endcase
  endtask

  task automatic end_line();
    case ($urandom_range(0, 2))
      0: line_buf.push_back(CHAR_CR);
      1: line_buf.push_back(CHAR_LF);
      default: begin
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_bytes++;
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
    sent_lines++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic directed_line(string s, sum_style_e st);
    put_text(s);
    put_sum(line_sum(), st);
    end_line();
    flush_line();
  endtask

  task automatic make_sentence();
    int         shape;
    int         nfields;
    sum_style_e st;
    case ($urandom_range(0, 9))
      0: line_buf.push_back(field_char());
      1, 2, 3, 4: line_buf.push_back(CHAR_BANG);
      default: line_buf.push_back(CHAR_DOLLAR);
    endcase
    shape = $urandom_range(0, 9);
    line_buf.push_back(8'($urandom_range(65, 90)));
    if (shape != 0) line_buf.push_back(8'($urandom_range(65, 90)));
    if ($urandom_range(0, 9) == 0) begin
      repeat (3) line_buf.push_back(8'($urandom_range(65, 90)));
    end else begin
      put_text(type_names[$urandom_range(0, 8)]);
    end
    if (shape == 1) line_buf.push_back(8'($urandom_range(65, 90)));
    nfields = $urandom_range(0, 24);
    repeat (nfields) begin
      line_buf.push_back(CHAR_COMMA);
      repeat ($urandom_range(0, 6)) line_buf.push_back(field_char());
    end
    if ($urandom_range(0, 1) == 0) st = sum_style_e'($urandom_range(SUM_UPPER, SUM_LOWER));
    else st = sum_style_e'($urandom_range(SUM_UPPER, NO_STAR));
    put_sum(line_sum(), st);
    end_line();
  endtask

  task automatic make_long();
    line_buf.push_back(CHAR_DOLLAR);
    repeat ($urandom_range(120, 160)) line_buf.push_back(body_byte());
    end_line();
  endtask

  task automatic make_noise();
    if ($urandom_range(0, 1) == 0) line_buf.push_back(CHAR_DOLLAR);
    repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) line_buf.push_back(CHAR_LF);
    end_line();
  endtask

  always @(posedge clk_i) begin
    int busy_out;
    busy_out = 0;
    if (out_valid_o && !out_stall_i) busy_out = 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || busy_out != 0) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    int line_no;
    int pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    line_buf.push_back(CHAR_CR);
    flush_line();
    line_buf.push_back(CHAR_LF);
    flush_line();
    directed_line("$GPMWV,12.5,R,4.1,N,A", SUM_UPPER);
    directed_line("!AIVDM,1,1,,A,13aG", SUM_LOWER);
    directed_line("!AIVDO", SUM_UPPER);
    directed_line("$GPHDT", SUM_TRAIL);
    directed_line("$GPRMC", NO_STAR);
    directed_line("$GPGGA,,,", SUM_ONE);
    directed_line("$GPVTG,x", SUM_WRONG);
    directed_line("$GPHDG,1", SUM_NONE);
    directed_line("$IIXDR,C,1", SUM_THREE);
    directed_line("$GPXDR,1", SUM_NONHEX);
    directed_line("$GPRMCX,1", SUM_UPPER);
    directed_line("$GPRM,1", SUM_UPPER);
    directed_line("GPRMC,1", SUM_UPPER);
    directed_line("$", SUM_UPPER);
    directed_line("$GPGGA,,,,,,,,,,,,,,,,,,,,,,,,", SUM_UPPER);
    line_buf.push_back(CHAR_DOLLAR);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    put_sum(line_sum(), SUM_UPPER);
    end_line();
    flush_line();
    drain();

    line_no = 0;
    while (sent_bytes < 600) begin
      if (line_no % 8 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) make_sentence();
      else if (pick < 79) make_long();
      else make_noise();
      flush_line();
      if (line_no % 25 == 24) drain();
      line_no++;
    end

    drain();
    repeat (6) @(posedge clk_i);
    $display("Framed %0d lines from %0d bytes; %0d line results compared.", sent_lines,
             sent_bytes, results_checked);
    $display("Covered sentence kinds, checksum forms, tag lengths, long and noisy lines.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
